// ===== rtl/mfom_pkg.sv =====
// mfom_pkg: shared widths, constants, codes and types for the field-oriented
// mecanum mixer; no dependencies, imported by every module of the block
package mfom_pkg;

  // angle resolution of the yaw encoder and the centre registers
  localparam int ANGLE_BITS  = 13;
  localparam int ANG_W       = 13;
  localparam int PHASE_W     = 16;
  localparam int PHASE_SHIFT = PHASE_W - ANGLE_BITS;
  localparam logic [PHASE_W-1:0] QUARTER_TURN = 16'h4000;

  // datapath widths
  localparam int CMD_W   = 16;
  localparam int LIMIT_W = 15;
  localparam int SIN_W   = 18;
  localparam int PROD_W  = CMD_W + SIN_W;
  localparam int RAW_W   = PROD_W + 1;
  localparam int ROT_W   = 18;
  localparam int MAG_W   = 17;
  localparam int SUM_W   = 18;
  localparam int NUM_W   = 32;
  localparam int QUO_W   = 15;

  // sine polynomial coefficients, q16
  localparam int SIN_A = 102944;
  localparam int SIN_B = 42048;
  localparam int SIN_C = 4640;

  // pipeline depths of the sine and divider units
  localparam int SIN_LAT = 6;
  localparam int DIV_LAT = QUO_W;

  // register reset values
  localparam logic [LIMIT_W-1:0] SPEED_LIMIT_RST  = 15'd8000;
  localparam logic [ANG_W-1:0]   SPIN_CENTRE_RST  = 13'd2100;
  localparam logic [ANG_W-1:0]   FRONT_CENTRE_RST = 13'd0;
  localparam logic [ANG_W-1:0]   BACK_CENTRE_RST  = 13'd4096;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_SPEED_LIMIT  = 2'd0,
    REG_SPIN_CENTRE  = 2'd1,
    REG_FRONT_CENTRE = 2'd2,
    REG_BACK_CENTRE  = 2'd3
  } cfg_reg_t;

  // heading mode codes
  typedef enum logic [1:0] {
    HEAD_NONE   = 2'd0,
    HEAD_SPIN   = 2'd1,
    HEAD_FOLLOW = 2'd2
  } heading_t;

  // command as it travels next to the sine units
  typedef struct packed {
    logic signed [CMD_W-1:0] f;
    logic signed [CMD_W-1:0] r;
    logic signed [CMD_W-1:0] w;
    logic                    rot;
  } cmd_t;

  // axis speeds after rotation
  typedef struct packed {
    logic signed [ROT_W-1:0] f;
    logic signed [ROT_W-1:0] r;
    logic signed [ROT_W-1:0] w;
  } axes_t;

  // what travels next to the dividers
  typedef struct packed {
    axes_t ax;
    logic  over;
  } lim_t;

  // saturate a wide signed value to 16 bits
  function automatic logic signed [CMD_W-1:0] sat16(input logic signed [ROT_W-1:0] v);
    logic signed [CMD_W-1:0] res;
    if (v > ROT_W'(32767)) begin
      res = 16'sh7FFF;
    end else if (v < -ROT_W'(32768)) begin
      res = 16'sh8000;
    end else begin
      res = v[CMD_W-1:0];
    end
    return res;
  endfunction

endpackage

// ===== rtl/mfom_sine.sv =====
// mfom_sine: six-stage q15 sine by quarter-wave reflection of an odd polynomial
// depends on mfom_pkg
module mfom_sine (
  input  logic                                clk,
  input  logic                                en,
  input  logic [mfom_pkg::PHASE_W-1:0]        phase,
  output logic signed [mfom_pkg::SIN_W-1:0]   sine
);
  import mfom_pkg::*;

  logic [14:0] z_a_r, z_b_r, z_c_r, z_d_r;
  logic        neg_a_r, neg_b_r, neg_c_r, neg_d_r, neg_e_r;
  logic [14:0] z2_b_r, z2_c_r;
  logic [12:0] t_c_r;
  logic [15:0] w_d_r;
  logic [16:0] s_e_r;
  logic signed [SIN_W-1:0] sine_r;

  logic [14:0] z_nxt;
  logic [29:0] zz;
  logic [27:0] tp;
  logic [15:0] u;
  logic [30:0] up;
  logic [16:0] v;
  logic [31:0] sp;

  // quadrant fold
  always_comb begin
    if (phase[14]) begin
      z_nxt = 15'(15'd16384 - {1'b0, phase[13:0]});
    end else begin
      z_nxt = {1'b0, phase[13:0]};
    end
  end

  // polynomial terms, one product per stage
  assign zz = 30'(z_a_r) * 30'(z_a_r);
  assign tp = 28'(SIN_C) * 28'(z2_b_r);
  assign u  = 16'(SIN_B) - 16'(t_c_r);
  assign up = 31'(u) * 31'(z2_c_r);
  assign v  = 17'(SIN_A) - 17'(w_d_r);
  assign sp = 32'(z_d_r) * 32'(v);

  always_ff @(posedge clk) begin
    if (en) begin
      z_a_r   <= z_nxt;
      neg_a_r <= phase[15];
      z2_b_r  <= zz[28:14];
      z_b_r   <= z_a_r;
      neg_b_r <= neg_a_r;
      t_c_r   <= tp[26:14];
      z2_c_r  <= z2_b_r;
      z_c_r   <= z_b_r;
      neg_c_r <= neg_b_r;
      w_d_r   <= up[29:14];
      z_d_r   <= z_c_r;
      neg_d_r <= neg_c_r;
      s_e_r   <= sp[31:15];
      neg_e_r <= neg_d_r;
      if (neg_e_r) begin
        sine_r <= -$signed({1'b0, s_e_r});
      end else begin
        sine_r <= $signed({1'b0, s_e_r});
      end
    end
  end

  assign sine = sine_r;

endmodule

// ===== rtl/mfom_div.sv =====
// mfom_div: pipelined restoring divider, one quotient bit per stage
// depends on mfom_pkg; the caller keeps the partial remainder below the divisor
module mfom_div (
  input  logic                           clk,
  input  logic                           en,
  input  logic [mfom_pkg::NUM_W-1:0]     num,
  input  logic [mfom_pkg::SUM_W-1:0]     den,
  output logic [mfom_pkg::QUO_W-1:0]     quo
);
  import mfom_pkg::*;

  logic [SUM_W-1:0] rem_r [DIV_LAT];
  logic [QUO_W-1:0] quo_r [DIV_LAT];
  logic [QUO_W-1:0] low_r [DIV_LAT];
  logic [SUM_W-1:0] den_r [DIV_LAT];

  logic [SUM_W-1:0] rem_in [DIV_LAT];
  logic [QUO_W-1:0] quo_in [DIV_LAT];
  logic [QUO_W-1:0] low_in [DIV_LAT];
  logic [SUM_W-1:0] den_in [DIV_LAT];

  for (genvar j = 0; j < DIV_LAT; j++) begin : g_step
    logic [SUM_W:0]   trial;
    logic             ge;
    logic [SUM_W-1:0] rem_nxt;
    logic [QUO_W-1:0] quo_nxt;

    // stage inputs
    if (j == 0) begin : g_first
      assign rem_in[j] = SUM_W'(num[NUM_W-1:QUO_W]);
      assign quo_in[j] = '0;
      assign low_in[j] = num[QUO_W-1:0];
      assign den_in[j] = den;
    end else begin : g_next
      assign rem_in[j] = rem_r[j-1];
      assign quo_in[j] = quo_r[j-1];
      assign low_in[j] = low_r[j-1];
      assign den_in[j] = den_r[j-1];
    end

    // trial subtract
    always_comb begin
      trial   = {rem_in[j], low_in[j][QUO_W-1-j]};
      ge      = (trial >= {1'b0, den_in[j]});
      quo_nxt = quo_in[j];
      quo_nxt[QUO_W-1-j] = ge;
      if (ge) begin
        rem_nxt = SUM_W'(trial - {1'b0, den_in[j]});
      end else begin
        rem_nxt = trial[SUM_W-1:0];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[j] <= rem_nxt;
        quo_r[j] <= quo_nxt;
        low_r[j] <= low_in[j];
        den_r[j] <= den_in[j];
      end
    end
  end

  assign quo = quo_r[DIV_LAT-1];

endmodule

// ===== rtl/mecanum_field_oriented_mixer_top.sv =====
// mecanum_field_oriented_mixer_top: field-oriented mecanum mixer, depends on mfom_pkg,
// mfom_sine and mfom_div. Each request (forward, sideways and rotate speed, yaw reading,
// heading mode, facing) gives one result: four wheel targets and the three axis speeds
// after turret-relative rotation and the speed limiter. The block is a 30-stage pipeline
// that takes one request per clock; out_valid is registered together with the output
// registers that hold the wheel targets and axis speeds. The depth is set by the
// six-stage sine units and the fifteen-stage dividers of the limiter. The whole pipeline
// holds while a result waits at the output with out_stall high, so in_stall follows
// out_stall in that case. Configuration writes are taken every cycle and should be made
// only while no request is in flight.
module mecanum_field_oriented_mixer_top (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // request channel
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [mfom_pkg::CMD_W-1:0]    in_forward_cmd,
  input  logic signed [mfom_pkg::CMD_W-1:0]    in_sideways_cmd,
  input  logic signed [mfom_pkg::CMD_W-1:0]    in_rotate_cmd,
  input  logic [mfom_pkg::ANG_W-1:0]           in_yaw_angle,
  input  logic [1:0]                           in_heading_mode,
  input  logic                                 in_facing_back,
  // result channel
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [mfom_pkg::CMD_W-1:0]    out_wheel_left_front,
  output logic signed [mfom_pkg::CMD_W-1:0]    out_wheel_right_front,
  output logic signed [mfom_pkg::CMD_W-1:0]    out_wheel_left_back,
  output logic signed [mfom_pkg::CMD_W-1:0]    out_wheel_right_back,
  output logic signed [mfom_pkg::CMD_W-1:0]    out_limited_forward,
  output logic signed [mfom_pkg::CMD_W-1:0]    out_limited_sideways,
  output logic signed [mfom_pkg::CMD_W-1:0]    out_limited_rotate,
  // configuration channel
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [1:0]                           cfg_index,
  input  logic [mfom_pkg::LIMIT_W-1:0]         cfg_data
);
  import mfom_pkg::*;

  localparam int LAST = SIN_LAT + DIV_LAT + 7;

  // configuration registers
  logic [LIMIT_W-1:0] speed_limit_r;
  logic [ANG_W-1:0]   spin_centre_r, front_centre_r, back_centre_r;

  // pipeline control
  logic            adv;
  logic [LAST:0]   vld_r;
  logic            out_valid_r;

  // stage 0
  logic            rot_nxt;
  logic [ANG_W-1:0]      centre;
  logic [ANGLE_BITS-1:0] ang_diff;
  logic [PHASE_W-1:0]    phase_nxt;
  cmd_t                  cmd0_r;
  logic [PHASE_W-1:0]    phs0_r, phc0_r;

  // sine stages
  cmd_t                    cmd_dly_r [SIN_LAT];
  logic signed [SIN_W-1:0] sin_val, cos_val;

  // rotation stages
  cmd_t                     cmd7_r, cmd8_r;
  logic signed [PROD_W-1:0] pfc_r, prs_r, pfs_r, prc_r;
  logic signed [RAW_W-1:0]  nf_raw_r, nr_raw_r;
  axes_t                    ax_nxt, ax9_r, ax10_r, ax11_r, ax12_r;

  // limiter stages
  logic [MAG_W-1:0]   magf10_r, magr10_r, magw10_r;
  logic [MAG_W-1:0]   magf11_r, magr11_r, magw11_r;
  logic [SUM_W-1:0]   sum_nxt, sum11_r, den12_r;
  logic               over11_r, over12_r;
  logic [LIMIT_W-1:0] lim11_r;
  logic [NUM_W-1:0]   numf12_r, numr12_r, numw12_r;
  logic [QUO_W-1:0]   quo_f, quo_r, quo_w;
  lim_t               lim_dly_r [DIV_LAT];
  lim_t               lim_out;
  logic signed [CMD_W-1:0] lf28_r, lr28_r, lw28_r;

  // output registers
  logic signed [CMD_W-1:0] wlf_r, wrf_r, wlb_r, wrb_r, lf_r, lr_r, lw_r;

  // truncate a q15 product toward zero
  function automatic logic signed [ROT_W-1:0] trunc_q15(input logic signed [RAW_W-1:0] raw);
    logic signed [RAW_W-1:0] biased;
    if (raw[RAW_W-1]) begin
      biased = raw + RAW_W'(32767);
    end else begin
      biased = raw;
    end
    return ROT_W'(biased >>> 15);
  endfunction

  // absolute value of an axis speed
  function automatic logic [MAG_W-1:0] mag_of(input logic signed [ROT_W-1:0] v);
    logic signed [ROT_W-1:0] a;
    a = v[ROT_W-1] ? -v : v;
    return a[MAG_W-1:0];
  endfunction

  // apply the limiter result with the sign of the original axis
  function automatic logic signed [CMD_W-1:0] limit_axis(input logic signed [ROT_W-1:0] v,
                                                         input logic [QUO_W-1:0] q,
                                                         input logic over);
    logic signed [ROT_W-1:0] qe;
    logic signed [ROT_W-1:0] res;
    qe = $signed({{(ROT_W-QUO_W){1'b0}}, q});
    if (!over) begin
      res = v;
    end else if (v[ROT_W-1]) begin
      res = -qe;
    end else begin
      res = qe;
    end
    return sat16(res);
  endfunction

  // handshake: the whole pipe moves unless a result is held at the output
  assign adv       = !out_valid_r || !out_stall;
  assign in_stall  = !adv;
  assign cfg_ready = 1'b1;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      speed_limit_r  <= SPEED_LIMIT_RST;
      spin_centre_r  <= SPIN_CENTRE_RST;
      front_centre_r <= FRONT_CENTRE_RST;
      back_centre_r  <= BACK_CENTRE_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_SPEED_LIMIT:  speed_limit_r  <= cfg_data;
        REG_SPIN_CENTRE:  spin_centre_r  <= cfg_data[ANG_W-1:0];
        REG_FRONT_CENTRE: front_centre_r <= cfg_data[ANG_W-1:0];
        REG_BACK_CENTRE:  back_centre_r  <= cfg_data[ANG_W-1:0];
        default: ;
      endcase
    end
  end

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      vld_r       <= {vld_r[LAST-1:0], in_valid};
      out_valid_r <= vld_r[LAST];
    end
  end

  // centre select by heading mode
  always_comb begin
    case (heading_t'(in_heading_mode))
      HEAD_SPIN: begin
        centre  = spin_centre_r;
        rot_nxt = 1'b1;
      end
      HEAD_FOLLOW: begin
        centre  = in_facing_back ? back_centre_r : front_centre_r;
        rot_nxt = 1'b1;
      end
      default: begin
        centre  = spin_centre_r;
        rot_nxt = 1'b0;
      end
    endcase
  end

  // phase between centre and yaw, widened to 16 bits
  assign ang_diff  = ANGLE_BITS'(centre) - ANGLE_BITS'(in_yaw_angle);
  assign phase_nxt = PHASE_W'(ang_diff) << PHASE_SHIFT;

  // stage 0: request capture
  always_ff @(posedge clk) begin
    if (adv) begin
      cmd0_r.f   <= in_forward_cmd;
      cmd0_r.r   <= in_sideways_cmd;
      cmd0_r.w   <= in_rotate_cmd;
      cmd0_r.rot <= rot_nxt;
      phs0_r     <= phase_nxt;
      phc0_r     <= phase_nxt + QUARTER_TURN;
    end
  end

  // sine and cosine
  mfom_sine u_sin (
    .clk   (clk),
    .en    (adv),
    .phase (phs0_r),
    .sine  (sin_val)
  );

  mfom_sine u_cos (
    .clk   (clk),
    .en    (adv),
    .phase (phc0_r),
    .sine  (cos_val)
  );

  // command delay next to the sine units
  always_ff @(posedge clk) begin
    if (adv) begin
      cmd_dly_r[0] <= cmd0_r;
      for (int k = 1; k < SIN_LAT; k++) begin
        cmd_dly_r[k] <= cmd_dly_r[k-1];
      end
    end
  end

  // rotation products
  always_ff @(posedge clk) begin
    if (adv) begin
      pfc_r  <= PROD_W'(cmd_dly_r[SIN_LAT-1].f) * PROD_W'(cos_val);
      prs_r  <= PROD_W'(cmd_dly_r[SIN_LAT-1].r) * PROD_W'(sin_val);
      pfs_r  <= PROD_W'(cmd_dly_r[SIN_LAT-1].f) * PROD_W'(sin_val);
      prc_r  <= PROD_W'(cmd_dly_r[SIN_LAT-1].r) * PROD_W'(cos_val);
      cmd7_r <= cmd_dly_r[SIN_LAT-1];
    end
  end

  // rotation sums
  always_ff @(posedge clk) begin
    if (adv) begin
      nf_raw_r <= RAW_W'(pfc_r) - RAW_W'(prs_r);
      nr_raw_r <= RAW_W'(pfs_r) + RAW_W'(prc_r);
      cmd8_r   <= cmd7_r;
    end
  end

  // truncate, or pass the translation through when not rotating
  always_comb begin
    if (cmd8_r.rot) begin
      ax_nxt.f = trunc_q15(nf_raw_r);
      ax_nxt.r = trunc_q15(nr_raw_r);
    end else begin
      ax_nxt.f = ROT_W'(cmd8_r.f);
      ax_nxt.r = ROT_W'(cmd8_r.r);
    end
    ax_nxt.w = ROT_W'(cmd8_r.w);
  end

  // absolute speeds
  always_ff @(posedge clk) begin
    if (adv) begin
      ax9_r    <= ax_nxt;
      ax10_r   <= ax9_r;
      magf10_r <= mag_of(ax9_r.f);
      magr10_r <= mag_of(ax9_r.r);
      magw10_r <= mag_of(ax9_r.w);
    end
  end

  // sum of absolute speeds against the limit
  assign sum_nxt = SUM_W'(magf10_r) + SUM_W'(magr10_r) + SUM_W'(magw10_r);

  always_ff @(posedge clk) begin
    if (adv) begin
      sum11_r  <= sum_nxt;
      over11_r <= (sum_nxt > SUM_W'(speed_limit_r));
      lim11_r  <= speed_limit_r;
      magf11_r <= magf10_r;
      magr11_r <= magr10_r;
      magw11_r <= magw10_r;
      ax11_r   <= ax10_r;
    end
  end

  // scaled numerators
  always_ff @(posedge clk) begin
    if (adv) begin
      numf12_r <= NUM_W'(magf11_r) * NUM_W'(lim11_r);
      numr12_r <= NUM_W'(magr11_r) * NUM_W'(lim11_r);
      numw12_r <= NUM_W'(magw11_r) * NUM_W'(lim11_r);
      den12_r  <= sum11_r;
      over12_r <= over11_r;
      ax12_r   <= ax11_r;
    end
  end

  // one divider per axis
  mfom_div u_div_f (
    .clk (clk),
    .en  (adv),
    .num (numf12_r),
    .den (den12_r),
    .quo (quo_f)
  );

  mfom_div u_div_r (
    .clk (clk),
    .en  (adv),
    .num (numr12_r),
    .den (den12_r),
    .quo (quo_r)
  );

  mfom_div u_div_w (
    .clk (clk),
    .en  (adv),
    .num (numw12_r),
    .den (den12_r),
    .quo (quo_w)
  );

  // axes and limit flag delayed next to the dividers
  always_ff @(posedge clk) begin
    if (adv) begin
      lim_dly_r[0].ax   <= ax12_r;
      lim_dly_r[0].over <= over12_r;
      for (int k = 1; k < DIV_LAT; k++) begin
        lim_dly_r[k] <= lim_dly_r[k-1];
      end
    end
  end

  assign lim_out = lim_dly_r[DIV_LAT-1];

  // limited axis speeds
  always_ff @(posedge clk) begin
    if (adv) begin
      lf28_r <= limit_axis(lim_out.ax.f, quo_f, lim_out.over);
      lr28_r <= limit_axis(lim_out.ax.r, quo_r, lim_out.over);
      lw28_r <= limit_axis(lim_out.ax.w, quo_w, lim_out.over);
    end
  end

  // mecanum mix into the output register
  always_ff @(posedge clk) begin
    if (adv) begin
      wlf_r <= sat16(ROT_W'(lf28_r) + ROT_W'(lr28_r) + ROT_W'(lw28_r));
      wrf_r <= sat16(-ROT_W'(lf28_r) + ROT_W'(lr28_r) + ROT_W'(lw28_r));
      wlb_r <= sat16(ROT_W'(lf28_r) - ROT_W'(lr28_r) + ROT_W'(lw28_r));
      wrb_r <= sat16(-ROT_W'(lf28_r) - ROT_W'(lr28_r) + ROT_W'(lw28_r));
      lf_r  <= lf28_r;
      lr_r  <= lr28_r;
      lw_r  <= lw28_r;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_wheel_left_front  = wlf_r;
  assign out_wheel_right_front = wrf_r;
  assign out_wheel_left_back   = wlb_r;
  assign out_wheel_right_back  = wrb_r;
  assign out_limited_forward   = lf_r;
  assign out_limited_sideways  = lr_r;
  assign out_limited_rotate    = lw_r;

`ifndef SYNTHESIS
  // limited axes never drive the wheel sums into saturation
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ($signed({wlf_r[CMD_W-1], wlf_r}) + $signed({wrb_r[CMD_W-1], wrb_r}))
                    == $signed({lw_r, 1'b0}))
    else $error("front-left plus back-right wheel does not match twice the rotation");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ($signed({wlf_r[CMD_W-1], wlf_r}) - $signed({wlb_r[CMD_W-1], wlb_r}))
                    == $signed({lr_r, 1'b0}))
    else $error("left wheels do not differ by twice the sideways speed");

  // a held pipeline keeps its last item
  assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r[LAST] && in_stall) |=> vld_r[LAST])
    else $error("item at the last stage lost while the pipeline was held");
`endif

endmodule

// ===== tb/tb_mecanum_field_oriented_mixer_top.sv =====
// tb_mecanum_field_oriented_mixer_top: self-checking bench for the field-oriented mecanum
// mixer, with a directed table, then random requests under several register settings
// depends on mfom_pkg and mecanum_field_oriented_mixer_top only
module tb_mecanum_field_oriented_mixer_top;
  import mfom_pkg::*;

  localparam logic [1:0] HEAD_UNUSED = 2'd3;
  localparam int DIR_N = 21;
  localparam int N_PHASE = 8;
  localparam int ITEMS_PER_PHASE = 200;
  localparam int PRESSURE_PHASE = 3;
  localparam int HOLD_CYCLES = 240;
  localparam int DRAIN_CYCLES = 40;
  localparam int IDLE_LIMIT = 2000;
  localparam int MAX_PRINTS = 40;

  // one request and one result of the mixer
  typedef struct packed {
    logic signed [CMD_W-1:0] f, r, w;
    logic [ANG_W-1:0]        yaw;
    logic [1:0]              mode;
    logic                    back;
  } mix_req_t;

  typedef struct packed {
    logic signed [CMD_W-1:0] lf, rf, lb, rb, fwd, side, rot;
  } wheel_set_t;

  // columns: f, r, w, yaw, mode, facing back, typed, then lf rf lb rb fwd side rot
  localparam int DIR_TAB [DIR_N][14] = '{
    '{0, 0, 0, 0, HEAD_NONE, 0, 1, 0, 0, 0, 0, 0, 0, 0},
    '{1000, 0, 0, 0, HEAD_NONE, 0, 1, 1000, -1000, 1000, -1000, 1000, 0, 0},
    '{0, 2000, 0, 8191, HEAD_NONE, 1, 1, 2000, 2000, -2000, -2000, 0, 2000, 0},
    '{0, 0, -3000, 0, HEAD_NONE, 0, 1, -3000, -3000, -3000, -3000, 0, 0, -3000},
    '{32767, 0, 0, 0, HEAD_NONE, 0, 1, 8000, -8000, 8000, -8000, 8000, 0, 0},
    '{-32768, 0, 0, 0, HEAD_NONE, 0, 1, -8000, 8000, -8000, 8000, -8000, 0, 0},
    '{0, 0, 32767, 0, HEAD_NONE, 0, 1, 8000, 8000, 8000, 8000, 0, 0, 8000},
    '{500, -500, 0, 1234, HEAD_UNUSED, 1, 1, 0, -1000, 1000, 0, 500, -500, 0},
    '{1234, -567, 89, 0, HEAD_FOLLOW, 0, 1, 756, -1712, 1890, -578, 1234, -567, 89},
    '{-100, 200, 300, 4096, HEAD_FOLLOW, 1, 1, 400, 600, 0, 200, -100, 200, 300},
    '{32767, 32767, 32767, 2100, HEAD_SPIN, 0, 1, 7998, 2666, 2666, -2666, 2666, 2666, 2666},
    '{-32768, -32768, -32768, 0, HEAD_SPIN, 0, 0, 0, 0, 0, 0, 0, 0, 0},
    '{32767, -32768, 0, 8191, HEAD_SPIN, 1, 0, 0, 0, 0, 0, 0, 0, 0},
    '{1000, 2000, 0, 0, HEAD_FOLLOW, 1, 0, 0, 0, 0, 0, 0, 0, 0},
    '{3000, 0, 0, 2048, HEAD_FOLLOW, 0, 0, 0, 0, 0, 0, 0, 0, 0},
    '{-32768, 32767, -32768, 8191, HEAD_FOLLOW, 1, 0, 0, 0, 0, 0, 0, 0, 0},
    '{4000, -3000, 500, 6144, HEAD_SPIN, 0, 0, 0, 0, 0, 0, 0, 0, 0},
    '{1, -1, 1, 1, HEAD_FOLLOW, 0, 0, 0, 0, 0, 0, 0, 0, 0},
    '{32767, 32767, 0, 1024, HEAD_FOLLOW, 0, 0, 0, 0, 0, 0, 0, 0, 0},
    '{-32768, -32768, 0, 7168, HEAD_FOLLOW, 1, 0, 0, 0, 0, 0, 0, 0, 0},
    '{0, 0, 0, 8191, HEAD_UNUSED, 1, 0, 0, 0, 0, 0, 0, 0, 0}
  };

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic signed [CMD_W-1:0] in_forward_cmd = '0;
  logic signed [CMD_W-1:0] in_sideways_cmd = '0;
  logic signed [CMD_W-1:0] in_rotate_cmd = '0;
  logic [ANG_W-1:0]        in_yaw_angle = '0;
  logic [1:0]              in_heading_mode = '0;
  logic                    in_facing_back = 1'b0;

  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic signed [CMD_W-1:0] out_wheel_left_front;
  logic signed [CMD_W-1:0] out_wheel_right_front;
  logic signed [CMD_W-1:0] out_wheel_left_back;
  logic signed [CMD_W-1:0] out_wheel_right_back;
  logic signed [CMD_W-1:0] out_limited_forward;
  logic signed [CMD_W-1:0] out_limited_sideways;
  logic signed [CMD_W-1:0] out_limited_rotate;

  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic [1:0]              cfg_index = '0;
  logic [LIMIT_W-1:0]      cfg_data = '0;

  // register shadows, at their reset values
  logic [LIMIT_W-1:0] lim_q = 15'd8000;
  logic [ANG_W-1:0]   spin_q = 13'd2100;
  logic [ANG_W-1:0]   front_q = 13'd0;
  logic [ANG_W-1:0]   back_q = 13'd4096;

  wheel_set_t wheel_exp_q[$];
  int err_cnt = 0;
  int n_sent = 0;
  int n_checked = 0;
  int n_in_held = 0;
  bit tx_idle_on = 1'b1;
  bit rx_idle_on = 1'b1;
  bit hold_req = 1'b0;

  mecanum_field_oriented_mixer_top u_top (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .in_forward_cmd        (in_forward_cmd),
    .in_sideways_cmd       (in_sideways_cmd),
    .in_rotate_cmd         (in_rotate_cmd),
    .in_yaw_angle          (in_yaw_angle),
    .in_heading_mode       (in_heading_mode),
    .in_facing_back        (in_facing_back),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_wheel_left_front  (out_wheel_left_front),
    .out_wheel_right_front (out_wheel_right_front),
    .out_wheel_left_back   (out_wheel_left_back),
    .out_wheel_right_back  (out_wheel_right_back),
    .out_limited_forward   (out_limited_forward),
    .out_limited_sideways  (out_limited_sideways),
    .out_limited_rotate    (out_limited_rotate),
    .cfg_valid             (cfg_valid),
    .cfg_ready             (cfg_ready),
    .cfg_index             (cfg_index),
    .cfg_data              (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // quarter-wave sine, 1.0 = 32768, truncating shifts on magnitudes
  function automatic longint sin_q15(logic [15:0] ph);
    longint z, z2, u, v, s;
    z = ph[14] ? 16384 - longint'(ph[13:0]) : longint'(ph[13:0]);
    z2 = (z * z) >> 14;
    u = SIN_B - ((SIN_C * z2) >> 14);
    v = SIN_A - ((u * z2) >> 14);
    s = (z * v) >> 15;
    return ph[15] ? -s : s;
  endfunction

  function automatic logic signed [CMD_W-1:0] clamp16(longint v);
    if (v > 32767) return 16'sh7FFF;
    if (v < -32768) return 16'sh8000;
    return 16'(v);
  endfunction

  // wheel targets: turret-relative rotation, speed limiter, mecanum mix
  function automatic wheel_set_t mix_predict(mix_req_t rq);
    longint f, r, w, nf, centre, s, c, sum, lim, amask;
    logic [15:0] ph;
    wheel_set_t res;
    f = $signed(rq.f);
    r = $signed(rq.r);
    w = $signed(rq.w);
    if (rq.mode == HEAD_SPIN || rq.mode == HEAD_FOLLOW) begin
      centre = (rq.mode == HEAD_SPIN) ? spin_q : (rq.back ? back_q : front_q);
      amask = (longint'(1) << ANGLE_BITS) - 1;
      ph = 16'(((centre - longint'(rq.yaw)) & amask) << PHASE_SHIFT);
      s = sin_q15(ph);
      c = sin_q15(ph + QUARTER_TURN);
      nf = (f * c - r * s) / 32768;
      r = (f * s + r * c) / 32768;
      f = nf;
    end
    sum = (f < 0 ? -f : f) + (r < 0 ? -r : r) + (w < 0 ? -w : w);
    lim = lim_q;
    if (sum > lim) begin
      f = f * lim / sum;
      r = r * lim / sum;
      w = w * lim / sum;
    end
    res.lf = clamp16(f + r + w);
    res.rf = clamp16(-f + r + w);
    res.lb = clamp16(f - r + w);
    res.rb = clamp16(-f - r + w);
    res.fwd = clamp16(f);
    res.side = clamp16(r);
    res.rot = clamp16(w);
    return res;
  endfunction

  // mostly short gaps, now and then a long one
  function automatic int pick_gap(bit on);
    int p;
    if (!on) return 0;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic signed [CMD_W-1:0] pick_val(int kind);
    if (kind <= 3) return 16'($urandom_range(0, 65535));
    if (kind <= 6) return 16'($urandom_range(0, 4000) - 2000);
    if (kind == 7) begin
      case ($urandom_range(0, 4))
        0: return 16'sh8000;
        1: return 16'shFFFF;
        2: return 16'sh0000;
        3: return 16'sh0001;
        default: return 16'sh7FFF;
      endcase
    end
    return 16'($urandom_range(0, 24000) - 12000);
  endfunction

  function automatic mix_req_t rand_req();
    mix_req_t rq;
    int kind, p;
    kind = $urandom_range(0, 9);
    rq.f = pick_val(kind);
    rq.r = pick_val(kind);
    rq.w = pick_val(kind);
    p = $urandom_range(0, 99);
    rq.mode = (p < 10) ? HEAD_UNUSED : 2'($urandom_range(0, 2));
    rq.back = 1'($urandom_range(0, 1));
    // yaw sometimes right on the active centre, sometimes at the ends
    p = $urandom_range(0, 99);
    if (p < 15) begin
      rq.yaw = (rq.mode == HEAD_SPIN) ? spin_q : (rq.back ? back_q : front_q);
    end else if (p < 25) begin
      rq.yaw = p[0] ? 13'h1FFF : 13'h0000;
    end else begin
      rq.yaw = 13'($urandom_range(0, 8191));
    end
    return rq;
  endfunction

  task automatic report(string what, longint got, longint want);
    err_cnt++;
    if (err_cnt <= MAX_PRINTS)
      $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
  endtask

  task automatic check_field(string what, logic signed [CMD_W-1:0] got,
                             logic signed [CMD_W-1:0] want);
    if (got !== want) report(what, got, want);
  endtask

  // register write, shadow updated on the handshake
  task automatic cfg_write(cfg_reg_t idx, logic [LIMIT_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_SPEED_LIMIT: lim_q = data;
      REG_SPIN_CENTRE: spin_q = data[ANG_W-1:0];
      REG_FRONT_CENTRE: front_q = data[ANG_W-1:0];
      default: back_q = data[ANG_W-1:0];
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // offer one request, queue its expected result once taken
  task automatic send_req(mix_req_t rq, bit typed, wheel_set_t typed_exp);
    int gap;
    gap = pick_gap(tx_idle_on);
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_forward_cmd <= rq.f;
    in_sideways_cmd <= rq.r;
    in_rotate_cmd <= rq.w;
    in_yaw_angle <= rq.yaw;
    in_heading_mode <= rq.mode;
    in_facing_back <= rq.back;
    @(posedge clk);
    while (in_stall) begin
      n_in_held++;
      @(posedge clk);
    end
    n_sent++;
    wheel_exp_q.push_back(typed ? typed_exp : mix_predict(rq));
  endtask

  task automatic check_result();
    wheel_set_t want;
    if (wheel_exp_q.size() == 0) begin
      report("result with no request pending, left front", out_wheel_left_front, 0);
    end else begin
      want = wheel_exp_q.pop_front();
      n_checked++;
      check_field("left front wheel", out_wheel_left_front, want.lf);
      check_field("right front wheel", out_wheel_right_front, want.rf);
      check_field("left back wheel", out_wheel_left_back, want.lb);
      check_field("right back wheel", out_wheel_right_back, want.rb);
      check_field("limited forward", out_limited_forward, want.fwd);
      check_field("limited sideways", out_limited_sideways, want.side);
      check_field("limited rotate", out_limited_rotate, want.rot);
    end
  endtask

  // result side
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) check_result();
  end

  // receiver stalls, plus one long hold-off on request
  initial begin : rx_side
    int len;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        len = HOLD_CYCLES;
      end else begin
        len = pick_gap(rx_idle_on);
      end
      if (len == 0) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= 1'b1;
        repeat (len - 1) @(negedge clk);
      end
    end
  end

  // no progress on any channel for too long ends the run
  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        idle = 0;
      else
        idle++;
    end
    $display("tb_mecanum_field_oriented_mixer_top: done, errors");
    $finish;
  end

  initial begin : main_seq
    mix_req_t rq;
    wheel_set_t typed_exp;
    int k, ph_i;
    logic [LIMIT_W-1:0] lim_v, spin_v, front_v, back_v;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed table under reset register values
    for (k = 0; k < DIR_N; k++) begin
      rq.f = 16'(DIR_TAB[k][0]);
      rq.r = 16'(DIR_TAB[k][1]);
      rq.w = 16'(DIR_TAB[k][2]);
      rq.yaw = 13'(DIR_TAB[k][3]);
      rq.mode = 2'(DIR_TAB[k][4]);
      rq.back = 1'(DIR_TAB[k][5]);
      typed_exp.lf = 16'(DIR_TAB[k][7]);
      typed_exp.rf = 16'(DIR_TAB[k][8]);
      typed_exp.lb = 16'(DIR_TAB[k][9]);
      typed_exp.rb = 16'(DIR_TAB[k][10]);
      typed_exp.fwd = 16'(DIR_TAB[k][11]);
      typed_exp.side = 16'(DIR_TAB[k][12]);
      typed_exp.rot = 16'(DIR_TAB[k][13]);
      send_req(rq, DIR_TAB[k][6] != 0, typed_exp);
    end
    @(negedge clk);
    in_valid <= 1'b0;

    // random requests, one register setting per phase
    for (ph_i = 0; ph_i < N_PHASE; ph_i++) begin
      while (wheel_exp_q.size() != 0) @(posedge clk);
      spin_v = 15'($urandom_range(0, 32767));
      front_v = 15'($urandom_range(0, 32767));
      back_v = 15'($urandom_range(0, 32767));
      tx_idle_on = 1'b1;
      rx_idle_on = 1'b1;
      case (ph_i)
        0: begin
          lim_v = 15'h7FFF;
          spin_v = 15'd0;
          front_v = 15'd8191;
          back_v = 15'd1;
        end
        1: lim_v = 15'd0;
        2: lim_v = 15'd1;
        3: begin
          lim_v = 15'($urandom_range(100, 32767));
          tx_idle_on = 1'b0;
        end
        4: begin
          // reset values again, upper data bits set to show they are dropped
          lim_v = 15'd8000;
          spin_v = 15'h6834;
          front_v = 15'h6000;
          back_v = 15'h3000;
        end
        5: lim_v = 15'($urandom_range(0, 100));
        6: lim_v = 15'($urandom_range(16000, 32767));
        default: begin
          lim_v = 15'h7FFF;
          tx_idle_on = 1'b0;
          rx_idle_on = 1'b0;
        end
      endcase
      cfg_write(REG_SPEED_LIMIT, lim_v);
      cfg_write(REG_SPIN_CENTRE, spin_v);
      cfg_write(REG_FRONT_CENTRE, front_v);
      cfg_write(REG_BACK_CENTRE, back_v);
      if (ph_i == PRESSURE_PHASE) hold_req = 1'b1;
      repeat (ITEMS_PER_PHASE) send_req(rand_req(), 1'b0, '0);
      @(negedge clk);
      in_valid <= 1'b0;
    end

    // drain and make sure nothing else shows up
    while (wheel_exp_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (wheel_exp_q.size() != 0) report("results still pending", wheel_exp_q.size(), 0);

    $display("ran %0d requests (%0d from the directed table) across %0d register settings",
             n_sent, DIR_N, N_PHASE + 1);
    $display("%0d results checked, input held off for %0d cycles, %0d mismatches",
             n_checked, n_in_held, err_cnt);
    if (err_cnt == 0) begin
      $display("tb_mecanum_field_oriented_mixer_top: done, clean");
    end else begin
      $display("tb_mecanum_field_oriented_mixer_top: done, errors");
    end
    $finish;
  end

endmodule
